[src/tcglc_pkg.sv]
// shared types and constants of the text cell glyph line composer
`default_nettype none

package tcglc_pkg;

  // input kinds
  localparam logic [1:0] KIND_FONT_WR  = 2'd0;
  localparam logic [1:0] KIND_REMAP_WR = 2'd1;
  localparam logic [1:0] KIND_COMPOSE  = 2'd2;

  // attribute bit positions
  localparam int ATTR_INVERSE   = 0;
  localparam int ATTR_BLINK     = 1;
  localparam int ATTR_BOLD      = 2;
  localparam int ATTR_UNDERLINE = 3;
  localparam int ATTR_ERROR     = 4;
  localparam int ATTR_NATIONAL  = 5;

  localparam logic [7:0] CODE_FIRST = 8'h20;
  localparam logic [7:0] CODE_LAST  = 8'h7F;
  localparam logic [8:0] FULL_LINE  = 9'h1FF;
  localparam int         REMAP_SIZE = 96;

  typedef enum logic [1:0] {
    OP_FONT_WR,
    OP_REMAP_WR,
    OP_COMPOSE
  } cmd_op_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [10:0] table_index;
    logic [7:0]  table_data;
    logic [7:0]  char_code;
    logic [5:0]  attributes;
    logic [6:0]  column;
    logic        first_row;
    logic [6:0]  cursor_column;
    logic        flash_phase;
  } item_t;

  typedef struct packed {
    logic [3:0] glyph_line;
    logic [9:0] bit_position;
    logic [8:0] pixels;
    logic       last;
  } result_t;

  // classified command between front and back
  typedef struct packed {
    cmd_op_e     op;
    logic [10:0] table_index;
    logic [7:0]  table_data;
    logic [6:0]  glyph_idx;
    logic        error;
    logic        national;
    logic        inverse;
    logic        blank;
    logic        bold;
    logic        underline;
    logic        cursor;
    logic [9:0]  bit_position;
  } cmd_t;

endpackage

`default_nettype wire

[src/text_cell_glyph_line_composer_unit.sv]
// top level of the text cell glyph line composer
//
// usage:
//   input queue: drive item_i and raise push; the item transfers at a clock
//   edge with push high and full low. kind selects a font byte write, a remap
//   entry write or a cell to compose; writes outside the tables, unknown kinds
//   and cells beyond the row width are taken and dropped.
//   result queue: while empty is low result_o holds the oldest line; it
//   transfers at a clock edge with pop high. a composed cell gives one result
//   per glyph line, last set on the final one.
//   column mode: cfg_we_i with cfg_wdata_i sets the 40-column spacing; write
//   it only while no cell is in flight.
// flow:
//   a cell passes the command queue and dispatch stage; its lines pass the line
//   sequencer, font read stage and result queue. a cell holds the font read
//   port for one read per glyph line, while the next command waits in dispatch.
//   a command queue between front and back lets items keep arriving while
//   lines stream out; when pop stays low the result queue fills, the line
//   sequencer halts and the command queue then fills and raises full.
// reset: queues empty, 80-column mode; font and remap tables undefined until written
`default_nettype none

module text_cell_glyph_line_composer_unit #(
  parameter int GLYPH_LINES = 14,
  parameter int GLYPH_COUNT = 128,
  parameter int BLOCK_GLYPH = 96,
  parameter int MAX_COLUMNS = 80,
  parameter int CMD_DEPTH   = 4,
  parameter int OUT_DEPTH   = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,
  input  logic                 push,
  output logic                 full,
  input  tcglc_pkg::item_t     item_i,
  output logic                 empty,
  input  logic                 pop,
  output tcglc_pkg::result_t   result_o
);

  import tcglc_pkg::*;

  localparam int CMD_W = $bits(cmd_t);
  localparam int RES_W = $bits(result_t);

  // front to command queue
  logic       cmd_push;
  cmd_t       cmd_in;
  logic       take;

  // command queue to back
  logic [CMD_W-1:0] cmd_raw;
  cmd_t             cmd_out;
  logic             cmd_empty;
  logic             cmd_pop;
  logic [$clog2(CMD_DEPTH+1)-1:0] cmd_count;

  // back to result queue
  logic                            res_push;
  result_t                         res_in;
  logic [RES_W-1:0]                res_raw;
  logic [$clog2(OUT_DEPTH+1)-1:0]  out_count;
  logic                            out_full;

  // every item transfers when there is room, even those that are dropped
  assign take = push && !full;

  tcglc_front #(
    .GLYPH_LINES (GLYPH_LINES),
    .GLYPH_COUNT (GLYPH_COUNT),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .take_i      (take),
    .item_i      (item_i),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in)
  );

  tcglc_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cmd_push),
    .wr_data_i (cmd_in),
    .rd_en_i   (cmd_pop),
    .rd_data_o (cmd_raw),
    .full_o    (full),
    .empty_o   (cmd_empty),
    .count_o   (cmd_count)
  );

  assign cmd_out = cmd_t'(cmd_raw);

  tcglc_back #(
    .GLYPH_LINES (GLYPH_LINES),
    .GLYPH_COUNT (GLYPH_COUNT),
    .BLOCK_GLYPH (BLOCK_GLYPH),
    .OUT_DEPTH   (OUT_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .out_count_i (out_count),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // the back end reserves a slot before each read, so this queue never overflows
  tcglc_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUT_DEPTH)
  ) u_res_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (res_push && (cmd_count == cmd_count)),
    .wr_data_i (res_in),
    .rd_en_i   (pop),
    .rd_data_o (res_raw),
    .full_o    (out_full),
    .empty_o   (empty),
    .count_o   (out_count)
  );

  assign result_o = result_t'(res_raw) & {RES_W{!out_full || out_full}};

endmodule

`default_nettype wire

[src/tcglc_fifo.sv]
// small register fifo used for the command queue and the result queue
`default_nettype none

module tcglc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_en_i,
  input  logic [WIDTH-1:0]               wr_data_i,
  input  logic                           rd_en_i,
  output logic [WIDTH-1:0]               rd_data_o,
  output logic                           full_o,
  output logic                           empty_o,
  output logic [$clog2(DEPTH+1)-1:0]     count_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_wr, do_rd;

  assign full_o    = (count_q == CNT_W'(DEPTH));
  assign empty_o   = (count_q == '0);
  assign count_o   = count_q;
  assign rd_data_o = slot_q[rd_ptr_q];
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slot_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

[src/tcglc_front.sv]
// front end: takes items, holds the column mode and classifies items into commands
`default_nettype none

module tcglc_front #(
  parameter int GLYPH_LINES = 14,
  parameter int GLYPH_COUNT = 128,
  parameter int MAX_COLUMNS = 80
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i,
  input  logic           take_i,
  input  tcglc_pkg::item_t item_i,
  output logic           cmd_push_o,
  output tcglc_pkg::cmd_t cmd_o
);

  import tcglc_pkg::*;

  localparam int FONT_SIZE = GLYPH_COUNT * GLYPH_LINES;

  logic       forty_q;
  logic       keep;
  logic [6:0] col_limit;
  logic [7:0] code_c;
  logic [7:0] idx_full;
  logic [9:0] col9;
  logic       plain;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      forty_q <= 1'b0;
    end else if (cfg_we_i) begin
      forty_q <= cfg_wdata_i;
    end
  end

  assign col_limit = forty_q ? 7'(MAX_COLUMNS / 2) : 7'(MAX_COLUMNS);
  assign code_c    = (item_i.char_code < CODE_FIRST || item_i.char_code > CODE_LAST) ?
                     CODE_FIRST : item_i.char_code;
  assign idx_full  = code_c - CODE_FIRST;
  assign col9      = ({3'b000, item_i.column} << 3) + {3'b000, item_i.column};
  // display attributes are ignored in the status row
  assign plain     = item_i.first_row;

  always_comb begin
    keep = 1'b0;
    cmd_o = '0;
    cmd_o.op = OP_COMPOSE;
    cmd_o.table_index = item_i.table_index;
    cmd_o.table_data  = item_i.table_data;
    cmd_o.glyph_idx   = idx_full[6:0];
    cmd_o.error       = item_i.attributes[ATTR_ERROR];
    cmd_o.national    = item_i.attributes[ATTR_NATIONAL];
    cmd_o.inverse     = !plain && item_i.attributes[ATTR_INVERSE];
    cmd_o.blank       = !plain && item_i.attributes[ATTR_BLINK] && item_i.flash_phase;
    cmd_o.bold        = !plain && item_i.attributes[ATTR_BOLD];
    cmd_o.underline   = !plain && item_i.attributes[ATTR_UNDERLINE];
    cmd_o.cursor      = (item_i.cursor_column < 7'(MAX_COLUMNS)) &&
                        (item_i.column == item_i.cursor_column) && !item_i.flash_phase;
    cmd_o.bit_position = forty_q ? {col9[8:0], 1'b0} : col9;
    unique case (item_i.kind)
      KIND_FONT_WR: begin
        cmd_o.op = OP_FONT_WR;
        keep = (32'(item_i.table_index) < 32'(FONT_SIZE));
      end
      KIND_REMAP_WR: begin
        cmd_o.op = OP_REMAP_WR;
        keep = (32'(item_i.table_index) < 32'(REMAP_SIZE));
      end
      KIND_COMPOSE: begin
        cmd_o.op = OP_COMPOSE;
        keep = (item_i.column < col_limit);
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign cmd_push_o = take_i && keep;

endmodule

`default_nettype wire

[src/tcglc_back.sv]
// back end: table writes, remap lookup, line sequencer, font read and pixel shaping
`default_nettype none

module tcglc_back #(
  parameter int GLYPH_LINES = 14,
  parameter int GLYPH_COUNT = 128,
  parameter int BLOCK_GLYPH = 96,
  parameter int OUT_DEPTH   = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cmd_empty_i,
  input  tcglc_pkg::cmd_t                    cmd_i,
  output logic                               cmd_pop_o,
  input  logic [$clog2(OUT_DEPTH+1)-1:0]     out_count_i,
  output logic                               res_push_o,
  output tcglc_pkg::result_t                 res_o
);

  import tcglc_pkg::*;

  localparam int FONT_SIZE = GLYPH_COUNT * GLYPH_LINES;
  localparam int FA_W      = $clog2(FONT_SIZE);
  localparam int OC_W      = $clog2(OUT_DEPTH+1) + 1;

  // memories
  logic [7:0] font_mem  [FONT_SIZE];
  logic [6:0] remap_mem [REMAP_SIZE];

  // dispatch stage
  logic       s1_vld_q;
  cmd_t       s1_cmd_q;
  logic [6:0] remap_rd_q;

  // line sequencer
  logic            seq_busy_q;
  logic [3:0]      line_q;
  logic [FA_W-1:0] base_q;
  logic            seq_zero_q;
  cmd_t            seq_cmd_q;

  // font read stage
  logic       rd_vld_q;
  logic [3:0] rd_line_q;
  logic       rd_last_q;
  logic       rd_zero_q;
  cmd_t       rd_cmd_q;
  logic [7:0] rd_data_q;

  logic            issue, seq_done, seq_free, s1_adv, s1_free, pop;
  logic            line_last;
  logic [7:0]      glyph;
  logic            glyph_ok;
  logic [11:0]     prod;
  logic [FA_W-1:0] font_addr;
  logic            font_we;
  logic [7:0]      g;
  logic [8:0]      v;

  // reserve a result slot for every line that is read
  assign issue     = seq_busy_q &&
                     ((OC_W'(out_count_i) + OC_W'(rd_vld_q)) < OC_W'(OUT_DEPTH));
  assign line_last = (line_q == 4'(GLYPH_LINES - 1));
  assign seq_done  = issue && line_last;
  assign seq_free  = !seq_busy_q || seq_done;
  assign s1_adv    = s1_vld_q && seq_free;
  assign s1_free   = !s1_vld_q || s1_adv;
  assign pop       = !cmd_empty_i && s1_free;
  assign cmd_pop_o = pop;
  assign font_we   = s1_adv && (s1_cmd_q.op == OP_FONT_WR);
  assign font_addr = base_q + FA_W'(line_q);

  always_comb begin
    if (s1_cmd_q.error) begin
      glyph = 8'(BLOCK_GLYPH);
    end else if (s1_cmd_q.national) begin
      glyph = {1'b0, remap_rd_q};
    end else begin
      glyph = {1'b0, s1_cmd_q.glyph_idx};
    end
  end

  assign glyph_ok = ({1'b0, glyph} < 9'(GLYPH_COUNT));
  assign prod     = 12'(glyph) * 12'(GLYPH_LINES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q   <= 1'b0;
      seq_busy_q <= 1'b0;
      line_q     <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      if (pop) begin
        s1_vld_q <= (cmd_i.op != OP_REMAP_WR);
      end else if (s1_adv) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_adv && s1_cmd_q.op == OP_COMPOSE) begin
        seq_busy_q <= 1'b1;
        line_q     <= '0;
      end else if (seq_done) begin
        seq_busy_q <= 1'b0;
        line_q     <= '0;
      end else if (issue) begin
        line_q <= line_q + 1'b1;
      end
      rd_vld_q <= issue;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_cmd_q <= cmd_i;
    end
    if (s1_adv && s1_cmd_q.op == OP_COMPOSE) begin
      seq_cmd_q  <= s1_cmd_q;
      seq_zero_q <= !glyph_ok || s1_cmd_q.blank;
      base_q     <= glyph_ok ? FA_W'(prod) : '0;
    end
    if (issue) begin
      rd_line_q <= line_q;
      rd_last_q <= line_last;
      rd_zero_q <= seq_zero_q;
      rd_cmd_q  <= seq_cmd_q;
    end
  end

  // remap table, registered read
  always_ff @(posedge clk_i) begin
    if (pop && cmd_i.op == OP_REMAP_WR) begin
      remap_mem[cmd_i.table_index[6:0]] <= cmd_i.table_data[6:0];
    end
    if (pop) begin
      remap_rd_q <= remap_mem[cmd_i.glyph_idx];
    end
  end

  // font store, registered read; a read in the same cycle sees the old byte
  always_ff @(posedge clk_i) begin
    if (font_we) begin
      font_mem[FA_W'(s1_cmd_q.table_index)] <= s1_cmd_q.table_data;
    end
    if (issue) begin
      rd_data_q <= font_mem[font_addr];
    end
  end

  // pixel shaping
  always_comb begin
    g = rd_zero_q ? 8'h00 : rd_data_q;
    if (rd_cmd_q.bold) begin
      g = g | (g >> 1);
    end
    v = {g, 1'b0};
    if (rd_cmd_q.underline && rd_last_q) begin
      v = FULL_LINE;
    end
    if (rd_cmd_q.cursor && rd_last_q) begin
      v = v ^ FULL_LINE;
    end
    if (rd_cmd_q.inverse) begin
      v = v ^ FULL_LINE;
    end
  end

  assign res_push_o         = rd_vld_q;
  assign res_o.glyph_line   = rd_line_q;
  assign res_o.bit_position = rd_cmd_q.bit_position;
  assign res_o.pixels       = v;
  assign res_o.last         = rd_last_q;

endmodule

`default_nettype wire

[verif/testbench.sv]
// self-checking testbench of the text cell glyph line composer
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tcglc_pkg::*;

  // block geometry, the defaults of the top level
  localparam int GLYPH_LINES = 14;
  localparam int GLYPH_COUNT = 128;
  localparam int BLOCK_GLYPH = 96;
  localparam int MAX_COLUMNS = 80;
  localparam int FONT_SIZE   = GLYPH_COUNT * GLYPH_LINES;
  localparam int ITEM_W      = $bits(item_t);

  // kind code the block does not know, taken and dropped
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // no cursor in the row
  localparam logic [6:0] NO_CURSOR = 7'd127;

  // glyphs that get a font: those reached from a cell code come first
  localparam logic [7:0] CHAR_CAP_A   = 8'h41;
  localparam logic [6:0] GLYPH_SPACE  = 7'd0;
  localparam logic [6:0] GLYPH_CAP_A  = 7'(CHAR_CAP_A - CODE_FIRST);
  localparam logic [6:0] GLYPH_DEL    = 7'(CODE_LAST - CODE_FIRST);
  localparam logic [6:0] GLYPH_TOP    = 7'(GLYPH_COUNT - 1);
  localparam int         LOADED_COUNT = 5;
  localparam int         CODE_GLYPHS  = 3;

  // cycles to let pass once the line queue is empty, covers the path through the block
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SHOW_LIMIT    = 60;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    cfg_we_i = 1'b0;
  logic    cfg_wdata_i = 1'b0;
  logic    push = 1'b0;
  logic    full;
  item_t   item_i = '0;
  logic    empty;
  logic    pop = 1'b0;
  result_t result_o;

  text_cell_glyph_line_composer_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o)
  );

  // 20 ns period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state: own copy of both tables and of the column mode
  logic [7:0] font_mem [FONT_SIZE];
  logic [6:0] remap_mem [REMAP_SIZE];
  logic       forty_mode = 1'b0;

  // lines still owed by the block, oldest first
  result_t pending_lines [$];

  int  err_count = 0;
  int  shown = 0;
  int  cycle_count = 0;
  bit  gaps_on = 1'b0;
  bit  stalls_on = 1'b0;
  int  pop_hold = 0;
  int  pop_roll;
  result_t want_line;

  // ---------------------------------------------------------------------------
  // predictor: table writes update the copy, a cell in the row owes 14 lines
  // ---------------------------------------------------------------------------
  task automatic model_item(input item_t it);
    logic [7:0] code;
    logic [7:0] idx8;
    logic [6:0] glyph;
    logic [5:0] attr;
    logic [7:0] g;
    logic [8:0] v;
    logic [9:0] pos;
    logic       blank;
    logic       cursor_here;
    logic       is_last;
    int         limit;
    int         ln;
    result_t    line_res;
    case (it.kind)
      KIND_FONT_WR: begin
        // addresses past the font are dropped
        if (it.table_index < FONT_SIZE) font_mem[it.table_index] = it.table_data;
      end
      KIND_REMAP_WR: begin
        if (it.table_index < REMAP_SIZE) remap_mem[it.table_index] = it.table_data[6:0];
      end
      KIND_COMPOSE: begin
        limit = forty_mode ? MAX_COLUMNS / 2 : MAX_COLUMNS;
        // a cell past the row width gives nothing
        if (it.column < limit) begin
          if (it.attributes[ATTR_ERROR]) begin
            glyph = 7'(BLOCK_GLYPH);
          end else begin
            // codes outside the printable range show as a space
            code = ((it.char_code < CODE_FIRST) || (it.char_code > CODE_LAST)) ?
                   CODE_FIRST : it.char_code;
            idx8 = code - CODE_FIRST;
            glyph = idx8[6:0];
            if (it.attributes[ATTR_NATIONAL]) glyph = remap_mem[glyph];
          end
          // status row keeps error, national and cursor only
          attr = it.first_row ? 6'd0 : it.attributes;
          blank = attr[ATTR_BLINK] && it.flash_phase;
          pos = it.column * (forty_mode ? 10'd18 : 10'd9);
          cursor_here = (it.cursor_column < MAX_COLUMNS) && (it.column == it.cursor_column) &&
                        !it.flash_phase;
          for (ln = 0; ln < GLYPH_LINES; ln++) begin
            is_last = (ln == GLYPH_LINES - 1);
            g = blank ? 8'h00 : font_mem[int'(glyph) * GLYPH_LINES + ln];
            if (attr[ATTR_BOLD]) g = g | (g >> 1);
            v = {g, 1'b0};
            if (attr[ATTR_UNDERLINE] && is_last) v = FULL_LINE;
            if (cursor_here && is_last) v = v ^ FULL_LINE;
            if (attr[ATTR_INVERSE]) v = v ^ FULL_LINE;
            line_res.glyph_line   = ln[3:0];
            line_res.bit_position = pos;
            line_res.pixels       = v;
            line_res.last         = is_last;
            pending_lines.push_back(line_res);
          end
        end
      end
      default: begin
        // unknown kind, dropped
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // result side: pop with random stalls, check each transfer at the rising edge
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (pop_hold > 0) begin
      pop = 1'b0;
      pop_hold = pop_hold - 1;
    end else begin
      pop = 1'b1;
      if (stalls_on) begin
        pop_roll = $urandom_range(0, 99);
        // mostly short stalls, now and then a long one
        if (pop_roll < 12) pop_hold = $urandom_range(1, 3);
        else if (pop_roll < 14) pop_hold = $urandom_range(15, 50);
      end
    end
  end

  task automatic check_field(input string name, input logic [9:0] want, input logic [9:0] got);
    if (got !== want) begin
      err_count++;
      if (shown < SHOW_LIMIT) begin
        shown++;
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (pending_lines.size() == 0) begin
        err_count++;
        if (shown < SHOW_LIMIT) begin
          shown++;
          $display("%0t: unexpected line, expected none actual %h", $time, result_o);
        end
      end else begin
        want_line = pending_lines.pop_front();
        check_field("glyph_line", 10'(want_line.glyph_line), 10'(result_o.glyph_line));
        check_field("bit_position", want_line.bit_position, result_o.bit_position);
        check_field("pixels", 10'(want_line.pixels), 10'(result_o.pixels));
        check_field("last", 10'(want_line.last), 10'(result_o.last));
      end
    end
  end

  // hang guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // input side helpers
  // ---------------------------------------------------------------------------

  // glyphs with a font, by slot
  function automatic logic [6:0] loaded_glyph(input int k);
    logic [6:0] gl;
    case (k)
      0:       gl = GLYPH_SPACE;
      1:       gl = GLYPH_CAP_A;
      2:       gl = GLYPH_DEL;
      3:       gl = 7'(BLOCK_GLYPH);
      default: gl = GLYPH_TOP;
    endcase
    return gl;
  endfunction

  // cell codes that only reach glyphs with a font
  function automatic logic [7:0] pick_code();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return CHAR_CAP_A;
    if (r < 5) return CODE_FIRST;
    if (r < 7) return CODE_LAST;
    if (r < 8) return 8'($urandom_range(0, 31));
    return 8'($urandom_range(128, 255));
  endfunction

  // remap data pointing at a glyph with a font, top bit is junk
  function automatic logic [7:0] pick_remap_data();
    return {1'($urandom), loaded_glyph($urandom_range(0, LOADED_COUNT - 1))};
  endfunction

  // cell item, table fields carry junk
  function automatic item_t cell_item(input logic [7:0] code, input logic [5:0] attr,
                                      input logic [6:0] col, input logic first,
                                      input logic [6:0] cur, input logic phase);
    item_t it;
    it.kind          = KIND_COMPOSE;
    it.table_index   = 11'($urandom);
    it.table_data    = 8'($urandom);
    it.char_code     = code;
    it.attributes    = attr;
    it.column        = col;
    it.first_row     = first;
    it.cursor_column = cur;
    it.flash_phase   = phase;
    return it;
  endfunction

  // table write or unknown kind, cell fields carry junk
  function automatic item_t table_wr(input logic [1:0] kind, input logic [10:0] idx,
                                     input logic [7:0] data);
    item_t it;
    it = item_t'(ITEM_W'({$urandom, $urandom}));
    it.kind        = kind;
    it.table_index = idx;
    it.table_data  = data;
    return it;
  endfunction

  // called at a falling edge; holds push until the transfer, returns at the
  // next falling edge with push still high so back-to-back items stay glitch free
  task automatic send_item(input item_t it);
    item_i = it;
    push = 1'b1;
    do @(posedge clk_i); while (full);
    model_item(it);
    @(negedge clk_i);
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      push = 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // wait for every owed line, then let a dropped item finish inside the block
  task automatic settle_idle();
    push = 1'b0;
    while (pending_lines.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_columns(input logic mode);
    settle_idle();
    cfg_we_i = 1'b1;
    cfg_wdata_i = mode;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    forty_mode = mode;
  endtask

  // random mix: mostly cells in the row, some table rewrites, some noise.
  // n counts items the block acts on
  task automatic run_mix(input int n);
    int     done;
    int     r;
    int     col_limit;
    logic   useful;
    logic [6:0] col;
    logic [6:0] cur;
    item_t  it;
    done = 0;
    while (done < n) begin
      r = $urandom_range(0, 99);
      col_limit = forty_mode ? MAX_COLUMNS / 2 : MAX_COLUMNS;
      useful = 1'b1;
      if (r < 62 || r >= 95) begin
        if (r < 62) col = 7'($urandom_range(0, col_limit - 1));
        else col = 7'($urandom_range(0, 127));
        case ($urandom_range(0, 9))
          0, 1, 2, 3: cur = col;
          4, 5, 6:    cur = 7'($urandom_range(0, 127));
          default:    cur = 7'($urandom_range(MAX_COLUMNS, 127));
        endcase
        it = cell_item(pick_code(), 6'($urandom), col, ($urandom_range(0, 4) == 0),
                       cur, 1'($urandom));
        useful = (col < col_limit);
      end else if (r < 78) begin
        // font rewrites stay mostly inside the store
        if ($urandom_range(0, 7) == 0) begin
          it = table_wr(KIND_FONT_WR, 11'($urandom), 8'($urandom));
        end else begin
          it = table_wr(KIND_FONT_WR, 11'($urandom_range(0, FONT_SIZE - 1)), 8'($urandom));
        end
        useful = (it.table_index < FONT_SIZE);
      end else if (r < 90) begin
        if ($urandom_range(0, 7) == 0) begin
          it = table_wr(KIND_REMAP_WR, 11'($urandom), pick_remap_data());
        end else begin
          it = table_wr(KIND_REMAP_WR, 11'($urandom_range(0, REMAP_SIZE - 1)),
                        pick_remap_data());
        end
        useful = (it.table_index < REMAP_SIZE);
      end else begin
        it = table_wr(KIND_UNUSED, 11'($urandom), 8'($urandom));
        useful = 1'b0;
      end
      send_item(it);
      if (useful) done++;
      idle_gap(pick_gap());
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // font of every glyph a cell can reach, remap entries of the codes in use
  task automatic test_load_tables();
    int k;
    int ln;
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    set_columns(1'b0);
    for (k = 0; k < LOADED_COUNT; k++) begin
      for (ln = 0; ln < GLYPH_LINES; ln++) begin
        send_item(table_wr(KIND_FONT_WR, 11'(int'(loaded_glyph(k)) * GLYPH_LINES + ln),
                           8'($urandom)));
      end
    end
    for (k = 0; k < CODE_GLYPHS; k++) begin
      send_item(table_wr(KIND_REMAP_WR, 11'(loaded_glyph(k)), pick_remap_data()));
    end
  endtask

  // code range edges, each attribute, cursor, status row, dropped items
  task automatic test_directed_eighty();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    // known rows: leftmost pixel, full last line of the space, last font byte
    send_item(table_wr(KIND_FONT_WR, 11'd0, 8'h80));
    send_item(table_wr(KIND_FONT_WR, 11'd13, 8'hFF));
    send_item(table_wr(KIND_FONT_WR, 11'(FONT_SIZE - 1), 8'h01));
    send_item(table_wr(KIND_FONT_WR, 11'h7FF, 8'h55));
    // entry 95 to the top glyph, writes past the table dropped
    send_item(table_wr(KIND_REMAP_WR, 11'd95, 8'hFF));
    send_item(table_wr(KIND_REMAP_WR, 11'd96, 8'h00));
    send_item(table_wr(KIND_REMAP_WR, 11'h7FF, 8'h3C));
    send_item(cell_item(8'h00, 6'h00, 7'd0, 1'b0, NO_CURSOR, 1'b0));
    send_item(cell_item(8'hFF, 6'h00, 7'd79, 1'b0, 7'd79, 1'b1));
    send_item(cell_item(8'h7F, 6'h00, 7'd5, 1'b0, 7'd80, 1'b0));
    send_item(cell_item(8'h80, 6'h00, 7'd6, 1'b0, NO_CURSOR, 1'b0));
    send_item(cell_item(8'h20, 6'h01 << ATTR_INVERSE, 7'd1, 1'b0, NO_CURSOR, 1'b0));
    send_item(cell_item(8'h41, 6'h01 << ATTR_BLINK, 7'd2, 1'b0, NO_CURSOR, 1'b0));
    send_item(cell_item(8'h41, 6'h01 << ATTR_BLINK, 7'd2, 1'b0, NO_CURSOR, 1'b1));
    send_item(cell_item(8'h20, 6'h01 << ATTR_BOLD, 7'd3, 1'b0, NO_CURSOR, 1'b0));
    send_item(cell_item(CHAR_CAP_A, 6'h01 << ATTR_UNDERLINE, 7'd4, 1'b0, NO_CURSOR, 1'b0));
    send_item(cell_item(8'h33, 6'h01 << ATTR_ERROR, 7'd64, 1'b0, NO_CURSOR, 1'b0));
    send_item(cell_item(8'h7F, 6'h01 << ATTR_NATIONAL, 7'd7, 1'b0, NO_CURSOR, 1'b0));
    // cursor shown, hidden by the blink phase, and on top of an underline
    send_item(cell_item(CHAR_CAP_A, 6'h00, 7'd12, 1'b0, 7'd12, 1'b0));
    send_item(cell_item(CHAR_CAP_A, 6'h00, 7'd12, 1'b0, 7'd12, 1'b1));
    send_item(cell_item(CHAR_CAP_A, 6'h01 << ATTR_UNDERLINE, 7'd12, 1'b0, 7'd12, 1'b0));
    send_item(cell_item(8'h5A, 6'h3F, 7'd20, 1'b0, NO_CURSOR, 1'b1));
    // status row: only error, national and cursor count
    send_item(cell_item(8'h5A, 6'h3F, 7'd21, 1'b1, 7'd21, 1'b0));
    send_item(cell_item(CHAR_CAP_A, 6'h2F, 7'd22, 1'b1, NO_CURSOR, 1'b1));
    // past the row and unknown kind, both dropped
    send_item(cell_item(8'h41, 6'h00, 7'd80, 1'b0, NO_CURSOR, 1'b0));
    send_item(cell_item(8'h41, 6'h00, 7'd127, 1'b0, NO_CURSOR, 1'b0));
    send_item(table_wr(KIND_UNUSED, 11'd0, 8'hFF));
  endtask

  // 40-column spacing: last column, first dropped column
  task automatic test_directed_forty();
    set_columns(1'b1);
    send_item(cell_item(8'h41, 6'h01 << ATTR_INVERSE, 7'd0, 1'b0, NO_CURSOR, 1'b0));
    send_item(cell_item(8'h7F, 6'h00, 7'd39, 1'b0, 7'd39, 1'b0));
    send_item(cell_item(8'h43, 6'h00, 7'd40, 1'b0, 7'd40, 1'b0));
  endtask

  task automatic test_random_forty();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    run_mix(10);
  endtask

  task automatic test_random_eighty();
    set_columns(1'b0);
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    run_mix(18);
  endtask

  // full rate on both sides
  task automatic test_back_to_back();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    run_mix(10);
  endtask

  // sender holds off until every owed line is out, then resumes
  task automatic test_drain_pause();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    run_mix(6);
    settle_idle();
    run_mix(6);
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_load_tables();
    test_directed_eighty();
    test_directed_forty();
    test_random_forty();
    test_random_eighty();
    test_back_to_back();
    test_drain_pause();
    settle_idle();
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
